// ----- design/v3alu_pkg.sv -----
// v3alu_pkg: shared types and constants for the three-lane vector alu
// depends on nothing

package v3alu_pkg;

  localparam int VecLen   = 3;
  localparam int FracDflt = 8;
  localparam int CfgW     = 48;
  localparam int CfgIdxW  = 2;

  typedef enum logic [3:0] {
    CMD_ADD   = 4'd0,
    CMD_SUB   = 4'd1,
    CMD_NEG   = 4'd2,
    CMD_SCALE = 4'd3,
    CMD_DOT   = 4'd4,
    CMD_CROSS = 4'd5,
    CMD_MAT   = 4'd6,
    CMD_NORM  = 4'd7,
    CMD_LEN   = 4'd8
  } cmd_t;

  localparam logic [CfgIdxW-1:0] REG_ROW0 = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_ROW1 = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_ROW2 = 2'd2;

  typedef struct packed {
    logic [3:0]         cmd;
    logic signed [15:0] a_x;
    logic signed [15:0] a_y;
    logic signed [15:0] a_z;
    logic signed [15:0] b_x;
    logic signed [15:0] b_y;
    logic signed [15:0] b_z;
    logic signed [15:0] factor;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] r_x;
    logic signed [15:0] r_y;
    logic signed [15:0] r_z;
    logic signed [15:0] scalar_out;
    logic               saturated;
  } out_word_t;

  // per-lane exact sum of products, wide enough for three 16x16 products
  typedef logic signed [34:0] acc_t;

  // clip to 16 bits, flag set when clipping happened
  function automatic logic [16:0] sat16(input logic signed [35:0] x);
    logic [16:0] r;
    if (x > 36'sd32767)       r = {1'b1, 16'h7fff};
    else if (x < -36'sd32768) r = {1'b1, 16'h8000};
    else                      r = {1'b0, x[15:0]};
    return r;
  endfunction

endpackage

// ----- design/v3alu_lane.sv -----
// v3alu_lane: one lane, forms three products and sums them exactly
// depends on v3alu_pkg

module v3alu_lane (
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [15:0]       p0,
  input  logic signed [15:0]       q0,
  input  logic signed [15:0]       p1,
  input  logic signed [15:0]       q1,
  input  logic signed [15:0]       p2,
  input  logic signed [15:0]       q2,
  output v3alu_pkg::acc_t          acc
);

  logic signed [31:0] m0_r, m1_r, m2_r;

  // products registered before the sum
  always_ff @(posedge clk) begin
    if (en) begin
      m0_r <= p0 * q0;
      m1_r <= p1 * q1;
      m2_r <= p2 * q2;
    end
  end

  assign acc = 35'(m0_r) + 35'(m1_r) + 35'(m2_r);

endmodule

// ----- design/v3alu_isqrt.sv -----
// v3alu_isqrt: pipelined bit-per-stage integer square root
// for normalize and length; depends on nothing

module v3alu_isqrt (
  input  logic        clk,
  input  logic        en,
  input  logic [33:0] sq,
  output logic [16:0] root
);

  // 17 result bits, one per stage
  localparam int NB = 17;

  logic [33:0] rem_r [NB+1];
  logic [16:0] res_r [NB+1];

  always_comb begin
    rem_r[0] = sq;
    res_r[0] = '0;
  end

  for (genvar s = 0; s < NB; s++) begin : g_st
    localparam int B = NB - 1 - s;
    logic [35:0] trial;
    logic [33:0] rem_nxt;
    logic [16:0] res_nxt;
    always_comb begin
      trial = ({19'd0, res_r[s]} << (B + 1)) + (36'd1 << (2 * B));
      if ({2'b0, rem_r[s]} >= trial) begin
        rem_nxt = 34'({2'b0, rem_r[s]} - trial);
        res_nxt = res_r[s] | (17'd1 << B);
      end else begin
        rem_nxt = rem_r[s];
        res_nxt = res_r[s];
      end
    end
    logic [33:0] rem_q;
    logic [16:0] res_q;
    always_ff @(posedge clk) begin
      if (en) begin
        rem_q <= rem_nxt;
        res_q <= res_nxt;
      end
    end
    assign rem_r[s+1] = rem_q;
    assign res_r[s+1] = res_q;
  end

  assign root = res_r[NB];

endmodule

// ----- design/v3alu_div.sv -----
// v3alu_div: pipelined restoring divider, magnitude of a*2^f over length
// depends on v3alu_pkg

module v3alu_div #(
  parameter int FRAC_BITS = v3alu_pkg::FracDflt
) (
  input  logic        clk,
  input  logic        en,
  input  logic [15:0] mag,
  input  logic [16:0] den,
  output logic [27:0] quo
);

  localparam int NW = 16 + FRAC_BITS;

  logic [NW-1:0] num_s [NW+1];
  logic [16:0]   rem_s [NW+1];
  logic [16:0]   den_s [NW+1];

  always_comb begin
    num_s[0] = NW'(mag) << FRAC_BITS;
    rem_s[0] = '0;
    den_s[0] = den;
  end

  for (genvar s = 0; s < NW; s++) begin : g_st
    logic [17:0] t;
    logic [16:0] rem_nxt;
    logic [NW-1:0] num_nxt;
    always_comb begin
      t = {rem_s[s], num_s[s][NW-1]};
      num_nxt = num_s[s] << 1;
      if (t >= {1'b0, den_s[s]}) begin
        rem_nxt = 17'(t - {1'b0, den_s[s]});
        num_nxt[0] = 1'b1;
      end else begin
        rem_nxt = t[16:0];
      end
    end
    logic [NW-1:0] num_q;
    logic [16:0]   rem_q, den_q;
    always_ff @(posedge clk) begin
      if (en) begin
        num_q <= num_nxt;
        rem_q <= rem_nxt;
        den_q <= den_s[s];
      end
    end
    assign num_s[s+1] = num_q;
    assign rem_s[s+1] = rem_q;
    assign den_s[s+1] = den_q;
  end

  assign quo = 28'(num_s[NW]);

endmodule

// ----- design/vector3_fixed_point_alu_core.sv -----
// vector3_fixed_point_alu_core: top level of the three-lane vector alu
// depends on v3alu_pkg, v3alu_lane, v3alu_isqrt, v3alu_div
//
//  channel | ports                        | direction
//  in      | in_valid in_ready in_data    | word in
//  out     | out_valid out_ready out_data | word out
//  cfg     | cfg_we cfg_idx cfg_data      | matrix row write
//
// one word enters per cycle unless the pipeline stalls; the accepting edge loads the
// product stage, and the word then passes the 17 root stages, the 16 + FRAC_BITS
// divide stages and the output register before it shows on out_data; the depth is
// set by the bit-per-stage square root and divider
// the whole pipeline advances together; it stalls while the output register
// holds a word not taken
// rst_n clears valid bits and the matrix to identity

module vector3_fixed_point_alu_core #(
  parameter int FRAC_BITS = v3alu_pkg::FracDflt
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  v3alu_pkg::in_word_t         in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output v3alu_pkg::out_word_t        out_data,
  input  logic                        cfg_we,
  input  logic [v3alu_pkg::CfgIdxW-1:0] cfg_idx,
  input  logic [v3alu_pkg::CfgW-1:0]  cfg_data
);

  localparam int DIVL = 16 + FRAC_BITS;
  // stages: 1 product, 17 root, DIVL divide, then output register
  localparam int LAT  = 1 + 17 + DIVL;
  localparam logic [16:0] One = 17'd1 << FRAC_BITS;

  logic [v3alu_pkg::CfgW-1:0] row_r [v3alu_pkg::VecLen];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r[0] <= 48'd256 << FRAC_BITS >> 8;
      row_r[1] <= (48'd256 << FRAC_BITS >> 8) << 16;
      row_r[2] <= (48'd256 << FRAC_BITS >> 8) << 32;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        v3alu_pkg::REG_ROW0: row_r[0] <= cfg_data;
        v3alu_pkg::REG_ROW1: row_r[1] <= cfg_data;
        v3alu_pkg::REG_ROW2: row_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipeline advances whenever the output slot is free or being drained
  logic adv;
  logic [LAT-1:0] vld_r;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      vld_r     <= {vld_r[LAT-2:0], in_valid};
      out_valid <= vld_r[LAT-1];
    end
  end

  // lane operand selection: lane k computes one output element
  logic signed [15:0] a [3];
  logic signed [15:0] b [3];
  logic signed [15:0] lp [3][3];
  logic signed [15:0] lq [3][3];
  v3alu_pkg::acc_t    acc [4];

  always_comb begin
    a[0] = in_data.a_x; a[1] = in_data.a_y; a[2] = in_data.a_z;
    b[0] = in_data.b_x; b[1] = in_data.b_y; b[2] = in_data.b_z;
    for (int k = 0; k < 3; k++) begin
      for (int t = 0; t < 3; t++) begin
        lp[k][t] = '0;
        lq[k][t] = '0;
      end
      case (in_data.cmd)
        v3alu_pkg::CMD_SCALE: begin
          lp[k][0] = a[k]; lq[k][0] = in_data.factor;
        end
        v3alu_pkg::CMD_CROSS: begin
          lp[k][0] = a[(k+1)%3]; lq[k][0] = b[(k+2)%3];
          lp[k][1] = a[(k+2)%3]; lq[k][1] = -b[(k+1)%3];
        end
        v3alu_pkg::CMD_MAT: begin
          for (int t = 0; t < 3; t++) begin
            lp[k][t] = a[t];
            lq[k][t] = row_r[t][16*k +: 16];
          end
        end
        default: ;
      endcase
    end
  end

  // note: -b of -32768 wraps; the correction term below restores the cross
  // term when it matters
  for (genvar k = 0; k < 3; k++) begin : g_lane
    v3alu_lane u_lane (
      .clk(clk), .en(adv),
      .p0(lp[k][0]), .q0(lq[k][0]),
      .p1(lp[k][1]), .q1(lq[k][1]),
      .p2(lp[k][2]), .q2(lq[k][2]),
      .acc(acc[k])
    );
  end

  // dot / norm lane: a.b or a.a
  logic is_sq;
  assign is_sq = (in_data.cmd == v3alu_pkg::CMD_NORM) ||
                 (in_data.cmd == v3alu_pkg::CMD_LEN);
  v3alu_lane u_dot (
    .clk(clk), .en(adv),
    .p0(a[0]), .q0(is_sq ? a[0] : b[0]),
    .p1(a[1]), .q1(is_sq ? a[1] : b[1]),
    .p2(a[2]), .q2(is_sq ? a[2] : b[2]),
    .acc(acc[3])
  );

  // cross products need the exact subtraction; the wrapped negation of
  // -32768 yields a*(-32768) where a*32768 is meant, so add back a*2^16
  logic signed [33:0] xfix_r [3];
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++)
        xfix_r[k] <= (in_data.cmd == v3alu_pkg::CMD_CROSS &&
                      b[(k+1)%3] == -16'sd32768) ?
                     (34'(a[(k+2)%3]) <<< 16) : 34'sd0;
    end
  end

  // simple (non-multiply) results and command, stage 1
  typedef struct packed {
    logic [3:0]          cmd;
    logic signed [15:0]  ax, ay, az;
    logic [16:0]         sx, sy, sz;
  } st_t;
  st_t s1_r;
  logic signed [16:0] e [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      case (in_data.cmd)
        v3alu_pkg::CMD_ADD: e[k] = 17'(a[k]) + 17'(b[k]);
        v3alu_pkg::CMD_SUB: e[k] = 17'(a[k]) - 17'(b[k]);
        default:            e[k] = -17'(a[k]);
      endcase
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r.cmd <= in_data.cmd;
      s1_r.ax  <= a[0]; s1_r.ay <= a[1]; s1_r.az <= a[2];
      s1_r.sx  <= v3alu_pkg::sat16(36'(e[0]));
      s1_r.sy  <= v3alu_pkg::sat16(36'(e[1]));
      s1_r.sz  <= v3alu_pkg::sat16(36'(e[2]));
    end
  end

  // shifted and saturated product results after stage 1
  logic [16:0] pr [4];
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      logic signed [35:0] x;
      x = 36'(acc[k]) + ((k < 3) ? 36'(xfix_r[k]) : 36'sd0);
      pr[k] = v3alu_pkg::sat16(x >>> FRAC_BITS);
    end
  end

  // mid result: everything except normalize and length, carried alongside root/divide
  typedef struct packed {
    logic [3:0]         cmd;
    logic signed [15:0] ax, ay, az;
    v3alu_pkg::out_word_t w;
  } mid_t;
  mid_t mid;
  always_comb begin
    mid.cmd = s1_r.cmd;
    mid.ax = s1_r.ax; mid.ay = s1_r.ay; mid.az = s1_r.az;
    mid.w = '0;
    case (s1_r.cmd) inside
      v3alu_pkg::CMD_ADD, v3alu_pkg::CMD_SUB, v3alu_pkg::CMD_NEG: begin
        mid.w.r_x = s1_r.sx[15:0]; mid.w.r_y = s1_r.sy[15:0];
        mid.w.r_z = s1_r.sz[15:0];
        mid.w.saturated = s1_r.sx[16] | s1_r.sy[16] | s1_r.sz[16];
      end
      v3alu_pkg::CMD_SCALE, v3alu_pkg::CMD_CROSS, v3alu_pkg::CMD_MAT: begin
        mid.w.r_x = pr[0][15:0]; mid.w.r_y = pr[1][15:0];
        mid.w.r_z = pr[2][15:0];
        mid.w.saturated = pr[0][16] | pr[1][16] | pr[2][16];
      end
      v3alu_pkg::CMD_DOT: begin
        mid.w.scalar_out = pr[3][15:0];
        mid.w.saturated  = pr[3][16];
      end
      default: ;
    endcase
  end

  // root over 17 stages; sum of squares fits 34 bits unsigned
  logic [16:0] root;
  v3alu_isqrt u_sqrt (.clk(clk), .en(adv), .sq(34'(acc[3])), .root(root));

  mid_t mid_d [18];
  always_comb mid_d[0] = mid;
  for (genvar s = 0; s < 17; s++) begin : g_md
    mid_t q;
    always_ff @(posedge clk) if (adv) q <= mid_d[s];
    assign mid_d[s+1] = q;
  end

  // after root: length result and divider launch
  mid_t m2;
  logic [16:0] len_sat;
  always_comb begin
    m2 = mid_d[17];
    len_sat = v3alu_pkg::sat16(36'(root));
    if (m2.cmd == v3alu_pkg::CMD_LEN) begin
      m2.w.scalar_out = len_sat[15:0];
      m2.w.saturated  = len_sat[16];
    end
  end

  logic [15:0] mg [3];
  logic        sg [3];
  logic [27:0] qo [3];
  always_comb begin
    sg[0] = m2.ax[15]; sg[1] = m2.ay[15]; sg[2] = m2.az[15];
    mg[0] = sg[0] ? 16'(-m2.ax) : m2.ax;
    mg[1] = sg[1] ? 16'(-m2.ay) : m2.ay;
    mg[2] = sg[2] ? 16'(-m2.az) : m2.az;
  end
  for (genvar k = 0; k < 3; k++) begin : g_div
    v3alu_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clk(clk), .en(adv), .mag(mg[k]),
      .den((root == 17'd0) ? 17'd1 : root), .quo(qo[k]));
  end

  typedef struct packed {
    mid_t m;
    logic passthru;
    logic [2:0] neg;
  } tail_t;
  tail_t tl_d [DIVL+1];
  always_comb begin
    tl_d[0].m = m2;
    tl_d[0].passthru = (root == 17'd0) || (root == One);
    tl_d[0].neg = {sg[2], sg[1], sg[0]};
  end
  for (genvar s = 0; s < DIVL; s++) begin : g_tl
    tail_t q;
    always_ff @(posedge clk) if (adv) q <= tl_d[s];
    assign tl_d[s+1] = q;
  end

  // merge stage: normalize results joined with the carried word
  v3alu_pkg::out_word_t fin;
  always_comb begin
    logic [16:0] c [3];
    tail_t t;
    t = tl_d[DIVL];
    fin = t.m.w;
    for (int k = 0; k < 3; k++)
      c[k] = v3alu_pkg::sat16(t.neg[k] ? -36'(qo[k]) : 36'(qo[k]));
    if (t.m.cmd == v3alu_pkg::CMD_NORM) begin
      if (t.passthru) begin
        fin.r_x = t.m.ax; fin.r_y = t.m.ay; fin.r_z = t.m.az;
        fin.saturated = 1'b0;
      end else begin
        fin.r_x = c[0][15:0]; fin.r_y = c[1][15:0]; fin.r_z = c[2][15:0];
        fin.saturated = c[0][16] | c[1][16] | c[2][16];
      end
    end
  end

  always_ff @(posedge clk) if (adv) out_data <= fin;

endmodule

// ----- design/v3alu_checker.sv -----
// v3alu_checker: port-level assertions for vector3_fixed_point_alu_core
// depends on v3alu_pkg

module v3alu_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input v3alu_pkg::out_word_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output word changed while stalled");

  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");

  a_ready_drain: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input blocked while output drains");

  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind vector3_fixed_point_alu_core v3alu_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data));

// ----- tb/testbench.sv -----
// testbench: self-checking bench for vector3_fixed_point_alu_core
// depends on v3alu_pkg and the core; predicts each result word internally unless
// the directed table types it; walks that table, then random words under several matrix settings
`timescale 1ns / 100ps

module testbench;

  localparam int HalfPeriod = 6;
  localparam int Latency    = 18 + 16 + v3alu_pkg::FracDflt;
  localparam int WatchLimit = 2000;
  localparam int RandPerSet = 80;
  localparam int NumSets    = 5;
  localparam int QuietTail  = 60;
  // register index past the last row: the core must ignore the write
  localparam logic [v3alu_pkg::CfgIdxW-1:0] REG_SPARE = 2'd3;
  localparam logic [v3alu_pkg::CfgW-1:0] ROW0_ID = 48'h0000_0000_0100;
  localparam logic [v3alu_pkg::CfgW-1:0] ROW1_ID = 48'h0000_0100_0000;
  localparam logic [v3alu_pkg::CfgW-1:0] ROW2_ID = 48'h0100_0000_0000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  v3alu_pkg::in_word_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  v3alu_pkg::out_word_t out_data;
  logic cfg_we = 1'b0;
  logic [v3alu_pkg::CfgIdxW-1:0] cfg_idx = '0;
  logic [v3alu_pkg::CfgW-1:0] cfg_data = '0;

  // the bench's own copy of the matrix
  logic [v3alu_pkg::CfgW-1:0] mat_row [v3alu_pkg::VecLen];

  v3alu_pkg::out_word_t pending_results[$];
  int mismatches = 0;
  int words_sent = 0;
  int words_checked = 0;
  int cmd_count [16];
  bit quiet = 1'b0;
  bit timed_out = 1'b0;

  typedef struct {
    v3alu_pkg::in_word_t  w;
    bit                   typed;
    v3alu_pkg::out_word_t res;
  } dir_row_t;

  always #HalfPeriod clk = ~clk;

  vector3_fixed_point_alu_core u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  // ---------------------------------------------------------------- predictor

  function automatic longint clip16(longint x, inout bit flag);
    if (x > 32767) begin
      flag = 1'b1;
      return 32767;
    end
    if (x < -32768) begin
      flag = 1'b1;
      return -32768;
    end
    return x;
  endfunction

  // bit-pair integer square root, floor
  function automatic longint unsigned root_floor(longint unsigned n);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic v3alu_pkg::out_word_t alu_result(v3alu_pkg::in_word_t w);
    longint a [3];
    longint b [3];
    longint r [3];
    longint s;
    longint f;
    longint acc;
    longint unsigned sq;
    longint unsigned len;
    bit flag;
    int p;
    int q;
    v3alu_pkg::out_word_t o;
    a[0] = w.a_x; a[1] = w.a_y; a[2] = w.a_z;
    b[0] = w.b_x; b[1] = w.b_y; b[2] = w.b_z;
    f = w.factor;
    r = '{0, 0, 0};
    s = 0;
    flag = 1'b0;
    case (w.cmd)
      v3alu_pkg::CMD_ADD:
        for (int i = 0; i < 3; i++) r[i] = clip16(a[i] + b[i], flag);
      v3alu_pkg::CMD_SUB:
        for (int i = 0; i < 3; i++) r[i] = clip16(a[i] - b[i], flag);
      v3alu_pkg::CMD_NEG:
        for (int i = 0; i < 3; i++) r[i] = clip16(-a[i], flag);
      // arithmetic shift of a signed longint is a floor
      v3alu_pkg::CMD_SCALE:
        for (int i = 0; i < 3; i++)
          r[i] = clip16((a[i] * f) >>> v3alu_pkg::FracDflt, flag);
      v3alu_pkg::CMD_DOT: begin
        acc = a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
        s = clip16(acc >>> v3alu_pkg::FracDflt, flag);
      end
      v3alu_pkg::CMD_CROSS: begin
        for (int i = 0; i < 3; i++) begin
          p = (i + 1) % 3;
          q = (p + 1) % 3;
          r[i] = clip16((a[p] * b[q] - a[q] * b[p]) >>> v3alu_pkg::FracDflt, flag);
        end
      end
      v3alu_pkg::CMD_MAT: begin
        for (int j = 0; j < 3; j++) begin
          acc = 0;
          for (int i = 0; i < 3; i++)
            acc += a[i] * longint'($signed(mat_row[i][16*j +: 16]));
          r[j] = clip16(acc >>> v3alu_pkg::FracDflt, flag);
        end
      end
      v3alu_pkg::CMD_NORM, v3alu_pkg::CMD_LEN: begin
        sq = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
        len = root_floor(sq);
        if (w.cmd == v3alu_pkg::CMD_LEN) begin
          s = clip16(longint'(len), flag);
        end else if (len == 0 || len == (64'd1 << v3alu_pkg::FracDflt)) begin
          // zero length and unit length pass a through untouched
          r = a;
        end else begin
          // signed division truncates toward zero
          for (int i = 0; i < 3; i++)
            r[i] = clip16((a[i] * (longint'(1) << v3alu_pkg::FracDflt)) /
                          longint'(len), flag);
        end
      end
      default: ;
    endcase
    o.r_x = r[0][15:0];
    o.r_y = r[1][15:0];
    o.r_z = r[2][15:0];
    o.scalar_out = s[15:0];
    o.saturated = flag;
    return o;
  endfunction

  // ---------------------------------------------------------------- helpers

  function automatic v3alu_pkg::in_word_t mk_word(logic [3:0] c, int ax, int ay, int az,
                                                  int bx, int by, int bz, int fac);
    v3alu_pkg::in_word_t w;
    w.cmd = c;
    w.a_x = ax[15:0]; w.a_y = ay[15:0]; w.a_z = az[15:0];
    w.b_x = bx[15:0]; w.b_y = by[15:0]; w.b_z = bz[15:0];
    w.factor = fac[15:0];
    return w;
  endfunction

  function automatic v3alu_pkg::out_word_t mk_res(int x, int y, int z, int s, bit sat);
    v3alu_pkg::out_word_t o;
    o.r_x = x[15:0]; o.r_y = y[15:0]; o.r_z = z[15:0];
    o.scalar_out = s[15:0];
    o.saturated = sat;
    return o;
  endfunction

  // operand values: extremes, small magnitudes and full-range noise
  function automatic int pick_operand(bit keep_small);
    int sel;
    sel = $urandom_range(0, 9);
    if (keep_small || sel < 4) return $urandom_range(0, 2047) - 1024;
    if (sel < 6) begin
      case ($urandom_range(0, 3))
        0: return 32767;
        1: return -32768;
        2: return 0;
        default: return -1;
      endcase
    end
    return $urandom_range(0, 65535) - 32768;
  endfunction

  function automatic v3alu_pkg::in_word_t random_word();
    logic [3:0] c;
    bit keep_small;
    // mostly legal commands, a few unknown codes
    if ($urandom_range(0, 15) == 0) c = 4'($urandom_range(9, 15));
    else c = 4'($urandom_range(0, 8));
    // keep root-based commands out of constant clipping most of the time
    keep_small = (c == v3alu_pkg::CMD_NORM || c == v3alu_pkg::CMD_LEN) &&
                 $urandom_range(0, 3) != 0;
    return mk_word(c, pick_operand(keep_small), pick_operand(keep_small),
                   pick_operand(keep_small), pick_operand(1'b0), pick_operand(1'b0),
                   pick_operand(1'b0), pick_operand(1'b0));
  endfunction

  // one register write, only while the core is idle
  task automatic write_reg(logic [v3alu_pkg::CfgIdxW-1:0] idx,
                           logic [v3alu_pkg::CfgW-1:0] value);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx <= v3alu_pkg::REG_ROW2) mat_row[idx] = value;
    @(posedge clk);
  endtask

  task automatic load_matrix(logic [v3alu_pkg::CfgW-1:0] r0, logic [v3alu_pkg::CfgW-1:0] r1,
                             logic [v3alu_pkg::CfgW-1:0] r2);
    write_reg(v3alu_pkg::REG_ROW0, r0);
    write_reg(v3alu_pkg::REG_ROW1, r1);
    write_reg(v3alu_pkg::REG_ROW2, r2);
    @(posedge clk);
  endtask

  // offer one word, hold it until taken, record what must come back
  task automatic send_word(v3alu_pkg::in_word_t w, v3alu_pkg::out_word_t res,
                           bit allow_gap);
    int gap;
    if (allow_gap && !quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 17);
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(res);
    words_sent++;
    cmd_count[w.cmd]++;
  endtask

  task automatic drain();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------- sink side

  // receiver stalls in bursts, none once the quiet tail starts
  initial begin
    int burst;
    @(posedge rst_n);
    forever begin
      if (!quiet && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        burst = $urandom_range(1, 17);
        repeat (burst) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  // result checker, sampled at the edge alongside the core
  always @(posedge clk) begin
    v3alu_pkg::out_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result word %h", $realtime, out_data);
      end else begin
        want = pending_results.pop_front();
        words_checked++;
        if (out_data.r_x !== want.r_x || out_data.r_y !== want.r_y ||
            out_data.r_z !== want.r_z || out_data.scalar_out !== want.scalar_out ||
            out_data.saturated !== want.saturated) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: mismatch exp x=%0d y=%0d z=%0d s=%0d sat=%0b got x=%0d y=%0d z=%0d s=%0d sat=%0b",
                     $realtime, want.r_x, want.r_y, want.r_z, want.scalar_out,
                     want.saturated, out_data.r_x, out_data.r_y, out_data.r_z,
                     out_data.scalar_out, out_data.saturated);
        end
      end
    end
  end

  // watchdog: cycles with work outstanding but no word moving
  always @(posedge clk) begin
    int idle_cycles;
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (pending_results.size() == 0 && !in_valid)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WatchLimit) begin
        timed_out = 1'b1;
        $display("vector3_fixed_point_alu_core verification failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  initial begin
    dir_row_t dir_rows[$];
    dir_row_t row;
    v3alu_pkg::in_word_t w;
    logic [v3alu_pkg::CfgW-1:0] rows [NumSets][3];
    int total_rand;

    mat_row[0] = ROW0_ID;
    mat_row[1] = ROW1_ID;
    mat_row[2] = ROW2_ID;
    foreach (cmd_count[i]) cmd_count[i] = 0;

    // directed table; typed results only where obvious
    dir_rows.push_back('{mk_word(v3alu_pkg::CMD_ADD, 32767, -32768, 1, 1, -1, 2, 0), 1'b1,
                         mk_res(32767, -32768, 3, 0, 1'b1)});
    dir_rows.push_back('{mk_word(v3alu_pkg::CMD_SUB, -32768, 32767, 0, 1, -1, 0, 0), 1'b1,
                         mk_res(-32768, 32767, 0, 0, 1'b1)});
    // negating the most negative value clips upward
    dir_rows.push_back('{mk_word(v3alu_pkg::CMD_NEG, -32768, 5, 0, 0, 0, 0, 0), 1'b1,
                         mk_res(32767, -5, 0, 0, 1'b1)});
    dir_rows.push_back('{mk_word(v3alu_pkg::CMD_SCALE, 256, -256, 32767, 0, 0, 0, 256),
                         1'b1, mk_res(256, -256, 32767, 0, 1'b0)});
    dir_rows.push_back('{mk_word(v3alu_pkg::CMD_SCALE, -1, 1, -32768, 0, 0, 0, -32768),
                         1'b0, '0});
    dir_rows.push_back('{mk_word(v3alu_pkg::CMD_DOT, 256, 256, 256, 256, 512, -256, 0),
                         1'b1, mk_res(0, 0, 0, 512, 1'b0)});
    dir_rows.push_back('{mk_word(v3alu_pkg::CMD_DOT, 32767, 32767, 32767, 32767, 32767,
                                 32767, 0), 1'b1, mk_res(0, 0, 0, 32767, 1'b1)});
    dir_rows.push_back('{mk_word(v3alu_pkg::CMD_CROSS, 256, 0, 0, 0, 256, 0, 0), 1'b1,
                         mk_res(0, 0, 256, 0, 1'b0)});
    dir_rows.push_back('{mk_word(v3alu_pkg::CMD_CROSS, -32768, 32767, -32768, 32767,
                                 -32768, 32767, 0), 1'b0, '0});
    // identity matrix after reset
    dir_rows.push_back('{mk_word(v3alu_pkg::CMD_MAT, 123, -456, 789, 0, 0, 0, 0), 1'b1,
                         mk_res(123, -456, 789, 0, 1'b0)});
    dir_rows.push_back('{mk_word(v3alu_pkg::CMD_LEN, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                         mk_res(0, 0, 0, 0, 1'b0)});
    dir_rows.push_back('{mk_word(v3alu_pkg::CMD_LEN, -32768, -32768, -32768, 0, 0, 0, 0),
                         1'b1, mk_res(0, 0, 0, 32767, 1'b1)});
    dir_rows.push_back('{mk_word(v3alu_pkg::CMD_LEN, 3, 4, 0, 0, 0, 0, 0), 1'b1,
                         mk_res(0, 0, 0, 5, 1'b0)});
    // zero length and unit length leave a unchanged
    dir_rows.push_back('{mk_word(v3alu_pkg::CMD_NORM, 0, 0, 0, 9, 9, 9, 9), 1'b1,
                         mk_res(0, 0, 0, 0, 1'b0)});
    dir_rows.push_back('{mk_word(v3alu_pkg::CMD_NORM, 0, -256, 0, 0, 0, 0, 0), 1'b1,
                         mk_res(0, -256, 0, 0, 1'b0)});
    dir_rows.push_back('{mk_word(v3alu_pkg::CMD_NORM, 1, 0, 0, 0, 0, 0, 0), 1'b0, '0});
    dir_rows.push_back('{mk_word(v3alu_pkg::CMD_NORM, 300, -400, 0, 0, 0, 0, 0), 1'b0, '0});
    dir_rows.push_back('{mk_word(v3alu_pkg::CMD_NORM, -32768, 32767, 1, 0, 0, 0, 0),
                         1'b0, '0});
    // unknown command codes give an all-zero word
    dir_rows.push_back('{mk_word(4'd9, 100, 100, 100, 1, 1, 1, 1), 1'b1,
                         mk_res(0, 0, 0, 0, 1'b0)});
    dir_rows.push_back('{mk_word(4'd15, -1, -1, -1, -1, -1, -1, -1), 1'b1,
                         mk_res(0, 0, 0, 0, 1'b0)});

    // matrix settings for the random sets: identity, all max, all min,
    // all minus one, random
    rows[0] = '{ROW0_ID, ROW1_ID, ROW2_ID};
    rows[1] = '{48'h7fff_7fff_7fff, 48'h7fff_7fff_7fff, 48'h7fff_7fff_7fff};
    rows[2] = '{48'h8000_8000_8000, 48'h8000_8000_8000, 48'h8000_8000_8000};
    rows[3] = '{48'hffff_ffff_ffff, 48'hffff_ffff_ffff, 48'hffff_ffff_ffff};
    rows[4] = '{{16'($urandom), 32'($urandom)}, {16'($urandom), 32'($urandom)},
                {16'($urandom), 32'($urandom)}};

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part on the reset matrix
    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      send_word(row.w, row.typed ? row.res : alu_result(row.w), 1'b1);
    end
    in_valid <= 1'b0;
    drain();

    total_rand = RandPerSet * NumSets;
    for (int set = 0; set < NumSets; set++) begin
      load_matrix(rows[set][0], rows[set][1], rows[set][2]);
      // a write to the spare index must leave the matrix alone
      if (set == 2) write_reg(REG_SPARE, 48'h1234_5678_9abc);
      for (int k = 0; k < RandPerSet; k++) begin
        if (set * RandPerSet + k >= total_rand - QuietTail) quiet = 1'b1;
        w = random_word();
        send_word(w, alu_result(w), 1'b1);
      end
      in_valid <= 1'b0;
      drain();
    end

    repeat (Latency + 10) @(posedge clk);

    $display("sent %0d words, checked %0d results over %0d matrix settings",
             words_sent, words_checked, NumSets + 1);
    $display("commands add..length: %0d %0d %0d %0d %0d %0d %0d %0d %0d",
             cmd_count[0], cmd_count[1], cmd_count[2], cmd_count[3], cmd_count[4],
             cmd_count[5], cmd_count[6], cmd_count[7], cmd_count[8]);
    if (mismatches == 0 && pending_results.size() == 0 && !timed_out) begin
      $display("vector3_fixed_point_alu_core verification clean");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, pending_results.size());
      $display("vector3_fixed_point_alu_core verification failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/v3alu_pkg.sv
design/v3alu_lane.sv
design/v3alu_isqrt.sv
design/v3alu_div.sv
design/vector3_fixed_point_alu_core.sv
design/v3alu_checker.sv
tb/testbench.sv
